// ===== rtl/core/rvr_pkg.sv =====
// ----------------------------------------------------------------------------
// Recency victim ranker package
// Field widths and the command and status bundles shared by the controller
// and the datapath.
// ----------------------------------------------------------------------------
package rvr_pkg;

    localparam int PAGE_ID_BITS = 32;
    localparam int SEQ_BITS     = 64;
    localparam int RANK_ID_BITS = 32;

    // Controller to datapath.
    typedef struct packed {
        logic load_en;     // candidate channel is open
        logic issue_read;  // read the next held candidate into the sorter
        logic emit_en;     // ranked channel is open
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic last_taken;      // final candidate of the set accepted this cycle
        logic reads_done;      // every held candidate has been read
        logic insert_pending;  // read data still on its way into the sorter
        logic run_done;        // final ranked beat taken this cycle
    } status_t;

endpackage

// ===== rtl/core/rvr_intf.sv =====
// ----------------------------------------------------------------------------
// Recency victim ranker channels
// Candidate and ranked-id channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface rvr_cand_if;
    logic                             valid;
    logic                             ready;
    logic [rvr_pkg::PAGE_ID_BITS-1:0] page_id;
    logic [rvr_pkg::SEQ_BITS-1:0]     access_seq;
    logic                             last_candidate;

    modport source (output valid, output page_id, output access_seq,
                    output last_candidate, input ready);
    modport sink   (input valid, input page_id, input access_seq,
                    input last_candidate, output ready);
endinterface

interface rvr_rank_if;
    logic                             valid;
    logic                             ready;
    logic [rvr_pkg::RANK_ID_BITS-1:0] ranked_id;
    logic                             last_ranked;
    logic                             overflow;

    modport source (output valid, output ranked_id, output last_ranked,
                    output overflow, input ready);
    modport sink   (input valid, input ranked_id, input last_ranked,
                    input overflow, output ready);
endinterface

// ===== rtl/core/rvr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rvr_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/rvr_sorter.sv =====
// ----------------------------------------------------------------------------
// Recency victim ranker insertion sorter
// A row of cells kept in ranked order; one insert or one pop per cycle.
// ----------------------------------------------------------------------------
module rvr_sorter #(
    parameter int ID_BITS = 32,
    parameter int DEPTH   = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         newest_first,
    input  logic                         insert_en,
    input  logic [ID_BITS-1:0]           insert_id,
    input  logic [rvr_pkg::SEQ_BITS-1:0] insert_seq,
    input  logic                         pop_en,
    output logic                         head_valid,
    output logic                         head_last,
    output logic [ID_BITS-1:0]           head_id
);
    import rvr_pkg::*;

    logic [ID_BITS-1:0]  id_reg    [DEPTH];
    logic [SEQ_BITS-1:0] seq_reg   [DEPTH];
    logic [DEPTH-1:0]    valid_reg;
    logic [DEPTH-1:0]    stays;

    function automatic logic ranks_before(
        input logic [ID_BITS-1:0]  ia,
        input logic [SEQ_BITS-1:0] sa,
        input logic [ID_BITS-1:0]  ib,
        input logic [SEQ_BITS-1:0] sb,
        input logic                newest
    );
        logic result;
        if (sa != sb)
        begin
            result = newest ? (sa > sb) : (sa < sb);
        end
        else
        begin
            result = ia < ib;
        end
        return result;
    endfunction

    // A cell keeps its entry when that entry ranks no later than the new one.
    // The cells form a sorted prefix, so these flags form a prefix as well.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            stays[i] = valid_reg[i] &&
                       !ranks_before(insert_id, insert_seq, id_reg[i], seq_reg[i],
                                     newest_first);
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[g] <= 1'b0;
                end
                else if (insert_en)
                begin
                    if (!stays[g])
                    begin
                        if (g == 0)
                        begin
                            valid_reg[g] <= 1'b1;
                        end
                        else
                        begin
                            valid_reg[g] <= stays[(g == 0) ? 0 : g-1] ||
                                            valid_reg[(g == 0) ? 0 : g-1];
                        end
                    end
                end
                else if (pop_en)
                begin
                    if (g == DEPTH-1)
                    begin
                        valid_reg[g] <= 1'b0;
                    end
                    else
                    begin
                        valid_reg[g] <= valid_reg[(g == DEPTH-1) ? g : g+1];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (insert_en)
                begin
                    if (!stays[g])
                    begin
                        if (g == 0 || stays[(g == 0) ? 0 : g-1])
                        begin
                            id_reg[g]  <= insert_id;
                            seq_reg[g] <= insert_seq;
                        end
                        else
                        begin
                            id_reg[g]  <= id_reg[(g == 0) ? 0 : g-1];
                            seq_reg[g] <= seq_reg[(g == 0) ? 0 : g-1];
                        end
                    end
                end
                else if (pop_en && g != DEPTH-1)
                begin
                    id_reg[g]  <= id_reg[(g == DEPTH-1) ? g : g+1];
                    seq_reg[g] <= seq_reg[(g == DEPTH-1) ? g : g+1];
                end
            end
        end
    endgenerate

    assign head_valid = valid_reg[0];
    assign head_last  = valid_reg[0] && !valid_reg[1];
    assign head_id    = id_reg[0];

endmodule

// ===== rtl/core/rvr_datapath.sv =====
// ----------------------------------------------------------------------------
// Recency victim ranker datapath
// Candidate store, read sequencing into the sorter and the ranked output.
// ----------------------------------------------------------------------------
module rvr_datapath #(
    parameter int MAX_CANDIDATES = 64,
    parameter int ID_BITS        = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  rvr_pkg::cmd_t       cmd,
    output rvr_pkg::status_t    status,
    rvr_cand_if.sink            cand,
    rvr_rank_if.source          rank
);
    import rvr_pkg::*;

    localparam int AW = $clog2(MAX_CANDIDATES);
    localparam int CW = $clog2(MAX_CANDIDATES + 1);
    localparam int DW = ID_BITS + SEQ_BITS;

    logic          prefetch_order_reg;
    logic [CW-1:0] held_count_reg;
    logic [CW-1:0] held_count_next;
    logic          dropped_reg;
    logic          dropped_next;
    logic [CW-1:0] rd_cnt_reg;
    logic [CW-1:0] rd_cnt_next;
    logic          rd_valid_reg;

    logic                cand_fire;
    logic                rank_fire;
    logic                has_room;
    logic [63:0]         id_wide;
    logic [DW-1:0]       wr_word;
    logic [DW-1:0]       rd_word;
    logic                head_valid;
    logic                head_last;
    logic [ID_BITS-1:0]  head_id;
    logic [63:0]         head_wide;

    assign cand.ready = cmd.load_en;
    assign cand_fire  = cand.valid && cmd.load_en;
    assign has_room   = held_count_reg < CW'(MAX_CANDIDATES);
    assign id_wide    = 64'(cand.page_id);
    assign wr_word    = {cand.access_seq, id_wide[ID_BITS-1:0]};

    rvr_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_CANDIDATES)
    ) u_store (
        .clk     (clk),
        .wr_en   (cand_fire && has_room),
        .wr_addr (held_count_reg[AW-1:0]),
        .wr_data (wr_word),
        .rd_en   (cmd.issue_read),
        .rd_addr (rd_cnt_reg[AW-1:0]),
        .rd_data (rd_word)
    );

    rvr_sorter #(
        .ID_BITS (ID_BITS),
        .DEPTH   (MAX_CANDIDATES)
    ) u_sorter (
        .clk          (clk),
        .rst_n        (rst_n),
        .newest_first (prefetch_order_reg),
        .insert_en    (rd_valid_reg),
        .insert_id    (rd_word[ID_BITS-1:0]),
        .insert_seq   (rd_word[DW-1:ID_BITS]),
        .pop_en       (rank_fire),
        .head_valid   (head_valid),
        .head_last    (head_last),
        .head_id      (head_id)
    );

    assign head_wide      = 64'(head_id);
    assign rank.valid     = cmd.emit_en && head_valid;
    assign rank.ranked_id = head_wide[RANK_ID_BITS-1:0];
    assign rank.last_ranked = head_last;
    assign rank.overflow  = dropped_reg;
    assign rank_fire      = rank.valid && rank.ready;

    always_comb
    begin
        held_count_next = held_count_reg;
        dropped_next    = dropped_reg;
        rd_cnt_next     = rd_cnt_reg;
        if (cand_fire)
        begin
            if (has_room)
            begin
                held_count_next = held_count_reg + CW'(1);
            end
            else
            begin
                dropped_next = 1'b1;
            end
            if (cand.last_candidate)
            begin
                rd_cnt_next = '0;
            end
        end
        if (cmd.issue_read)
        begin
            rd_cnt_next = rd_cnt_reg + CW'(1);
        end
        // The run ends with its final ranked beat; the store starts over.
        if (rank_fire && head_last)
        begin
            held_count_next = '0;
            dropped_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefetch_order_reg <= 1'b0;
            held_count_reg     <= '0;
            dropped_reg        <= 1'b0;
            rd_cnt_reg         <= '0;
            rd_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                prefetch_order_reg <= cfg_wr_data;
            end
            held_count_reg <= held_count_next;
            dropped_reg    <= dropped_next;
            rd_cnt_reg     <= rd_cnt_next;
            rd_valid_reg   <= cmd.issue_read;
        end
    end

    assign status.last_taken     = cand_fire && cand.last_candidate;
    assign status.reads_done     = rd_cnt_reg == held_count_reg;
    assign status.insert_pending = rd_valid_reg;
    assign status.run_done       = rank_fire && head_last;

endmodule

// ===== rtl/core/rvr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Recency victim ranker controller
// Sequences the load, sort and emit phases of one run.
// ----------------------------------------------------------------------------
module rvr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  rvr_pkg::status_t status,
    output rvr_pkg::cmd_t    cmd
);
    import rvr_pkg::*;

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd.load_en    = 1'b0;
        cmd.issue_read = 1'b0;
        cmd.emit_en    = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                cmd.load_en = 1'b1;
                if (status.last_taken)
                begin
                    state_next = ST_SORT;
                end
            end
            ST_SORT:
            begin
                cmd.issue_read = !status.reads_done;
                // Wait for the final read to land in the sorter.
                if (status.reads_done && !status.insert_pending)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit_en = 1'b1;
                if (status.run_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/recency_victim_ranker_core.sv =====
// ----------------------------------------------------------------------------
// Recency victim ranker
// Collects candidate pages and returns their ids in recency order.
// ----------------------------------------------------------------------------
// Candidates come in on cand, one beat per cycle, each with a page id and the
// sequence number of its last access; the beat with last_candidate closes
// the set. Up to MAX_CANDIDATES are kept, later ones are dropped and every
// ranked beat of that run then shows overflow. cfg_wr_en/cfg_wr_data set the
// order: 0 puts the oldest access first, 1 the newest; equal sequences go by
// ascending page id. Write it only between runs.
// After the closing candidate the n held entries are read from the candidate
// RAM, one per cycle, into an insertion sorter. The ids then leave on rank at
// one beat per cycle while rank is ready, the final one flagged with
// last_ranked. cand is closed from the closing beat until the final ranked
// beat is taken. A stall on rank holds the head beat in place. Reset empties
// the block and selects oldest-first order.
// ----------------------------------------------------------------------------
module recency_victim_ranker_core #(
    parameter int MAX_CANDIDATES = 64,
    parameter int ID_BITS        = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    rvr_cand_if.sink    cand,
    rvr_rank_if.source  rank
);
    import rvr_pkg::*;

    cmd_t    cmd;
    status_t status;

    rvr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    rvr_datapath #(
        .MAX_CANDIDATES (MAX_CANDIDATES),
        .ID_BITS        (ID_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .cand        (cand),
        .rank        (rank)
    );

endmodule

// ===== dv/rvr_ranking_checker.sv =====
// ----------------------------------------------------------------------------
// Recency ranking checker
// Watches the candidate, ranked-id and order-register traffic, works out the
// ranked ids that each closed candidate set must produce, and compares every
// ranked beat with the oldest of them.
// ----------------------------------------------------------------------------
module rvr_ranking_checker #(
    parameter int MAX_CANDIDATES = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_wr_en,
    input  logic cfg_wr_data,
    rvr_cand_if  cand,
    rvr_rank_if  rank,
    output int   fail_count,
    output int   outstanding
);

    typedef struct {
        logic [rvr_pkg::PAGE_ID_BITS-1:0] id;
        logic [rvr_pkg::SEQ_BITS-1:0]     seq;
    } candidate_t;

    typedef struct {
        logic [rvr_pkg::RANK_ID_BITS-1:0] ranked_id;
        logic                             last_ranked;
        logic                             overflow;
    } ranked_beat_t;

    candidate_t   held_q[$];
    ranked_beat_t ranked_q[$];
    logic         dropped;
    logic         newest_first;

    function automatic bit goes_first(candidate_t a, candidate_t b, logic newest);
        if (a.seq != b.seq)
            return newest ? (a.seq > b.seq) : (a.seq < b.seq);
        return a.id < b.id;
    endfunction

    // Sort the held set and queue one ranked beat per entry.
    function automatic void rank_held_set();
        candidate_t   sorted_q[$];
        ranked_beat_t beat;
        int           j;
        foreach (held_q[i])
        begin
            j = sorted_q.size();
            while (j > 0 && goes_first(held_q[i], sorted_q[j-1], newest_first))
                j--;
            sorted_q.insert(j, held_q[i]);
        end
        foreach (sorted_q[i])
        begin
            beat.ranked_id   = sorted_q[i].id;
            beat.last_ranked = (i == sorted_q.size() - 1);
            beat.overflow    = dropped;
            ranked_q.insert(ranked_q.size(), beat);
        end
        held_q.delete();
        dropped = 1'b0;
    endfunction

    function automatic void take_candidate();
        candidate_t c;
        c.id  = cand.page_id;
        c.seq = cand.access_seq;
        if (held_q.size() < MAX_CANDIDATES)
            held_q.insert(held_q.size(), c);
        else
            dropped = 1'b1;
        if (cand.last_candidate)
            rank_held_set();
    endfunction

    function automatic void check_ranked_beat();
        ranked_beat_t exp_beat;
        if (ranked_q.size() == 0)
        begin
            $error("ranked beat with no expectation: ranked_id %h", rank.ranked_id);
            fail_count++;
            return;
        end
        exp_beat = ranked_q.pop_front();
        if (rank.ranked_id !== exp_beat.ranked_id)
        begin
            $error("ranked_id: expected %h, actual %h", exp_beat.ranked_id, rank.ranked_id);
            fail_count++;
        end
        if (rank.last_ranked !== exp_beat.last_ranked)
        begin
            $error("last_ranked: expected %b, actual %b",
                   exp_beat.last_ranked, rank.last_ranked);
            fail_count++;
        end
        if (rank.overflow !== exp_beat.overflow)
        begin
            $error("overflow: expected %b, actual %b", exp_beat.overflow, rank.overflow);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_q.delete();
            ranked_q.delete();
            dropped      = 1'b0;
            newest_first = 1'b0;
            fail_count   = 0;
            outstanding  = 0;
        end
        else
        begin
            // The order in force before this edge applies to a set closed at it.
            if (cand.valid && cand.ready)
                take_candidate();
            if (cfg_wr_en)
                newest_first = cfg_wr_data;
            if (rank.valid && rank.ready)
                check_ranked_beat();
            outstanding = ranked_q.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Recency victim ranker testbench
// Drives candidate sets through the ranker under both orders, with random
// gaps on the candidate side and random stalls on the ranked side, and
// reports the verdict of the ranking checker.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_CANDIDATES = 64;
    localparam int QUIET_LIMIT    = 1000;
    localparam int RANDOM_ITEMS   = 245;
    localparam int MIN_SETS       = 10;

    localparam logic ORDER_OLDEST_FIRST = 1'b0;
    localparam logic ORDER_NEWEST_FIRST = 1'b1;

    localparam logic [63:0] SEQ_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;
    logic calm;
    int   fail_count;
    int   outstanding;
    int   quiet_cycles;

    rvr_cand_if cand_if ();
    rvr_rank_if rank_if ();

    recency_victim_ranker_core #(
        .MAX_CANDIDATES (MAX_CANDIDATES),
        .ID_BITS        (32)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cand        (cand_if),
        .rank        (rank_if)
    );

    rvr_ranking_checker #(
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cand        (cand_if),
        .rank        (rank_if),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        rank_if.ready <= calm || ($urandom_range(99) >= 16);

    always @(posedge clk)
    begin
        if (!rst_n || (cand_if.valid && cand_if.ready) || (rank_if.valid && rank_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** recency_victim_ranker_core: FAILED **");
            $finish;
        end
    end

    task automatic send_candidate(input logic [31:0] id, input logic [63:0] seq,
                                  input logic last);
        while (!calm && $urandom_range(99) < 16)
        begin
            cand_if.valid <= 1'b0;
            @(posedge clk);
        end
        cand_if.valid          <= 1'b1;
        cand_if.page_id        <= id;
        cand_if.access_seq     <= seq;
        cand_if.last_candidate <= last;
        @(posedge clk);
        while (!cand_if.ready)
            @(posedge clk);
    endtask

    // Hold the sender until every ranked beat is back, then let the block settle.
    task automatic drain_results();
        cand_if.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_order(input logic order);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= order;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [63:0] pick_seq(int flavor);
        case (flavor)
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(3));
            2:
            begin
                case ($urandom_range(3))
                    0: return 64'd0;
                    1: return SEQ_MAX;
                    2: return 64'd1;
                    default: return SEQ_MAX - 64'd1;
                endcase
            end
            default: return {32'h0, $urandom};
        endcase
    endfunction

    function automatic logic [31:0] pick_id(int flavor);
        if (flavor == 1 || $urandom_range(9) == 0)
            return 32'($urandom_range(7));
        return $urandom;
    endfunction

    initial
    begin
        int set_no;
        int items;
        int set_size;
        int flavor;

        rst_n                  = 1'b0;
        calm                   = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_wr_data            = 1'b0;
        cand_if.valid          = 1'b0;
        cand_if.page_id        = '0;
        cand_if.access_seq     = '0;
        cand_if.last_candidate = 1'b0;
        rank_if.ready          = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Oldest first: a lone candidate, then extremes and a sequence tie.
        write_order(ORDER_OLDEST_FIRST);
        send_candidate(32'h0000_0000, 64'd0, 1'b1);
        send_candidate(32'hFFFF_FFFF, SEQ_MAX, 1'b0);
        send_candidate(32'h0000_0007, 64'd0, 1'b0);
        send_candidate(32'h0000_0009, 64'd5, 1'b0);
        send_candidate(32'h0000_0003, 64'd5, 1'b0);
        send_candidate(32'h8000_0000, 64'h8000_0000_0000_0000, 1'b1);

        // Newest first, with a duplicated entry in the set.
        write_order(ORDER_NEWEST_FIRST);
        send_candidate(32'h0000_0009, 64'd5, 1'b0);
        send_candidate(32'h0000_0009, 64'd5, 1'b0);
        send_candidate(32'h0000_0003, 64'd5, 1'b0);
        send_candidate(32'hFFFF_FFFF, SEQ_MAX, 1'b0);
        send_candidate(32'h0000_0000, 64'd0, 1'b0);
        send_candidate(32'h0000_0001, 64'd1, 1'b1);
        send_candidate(32'h1234_5678, 64'hDEAD_BEEF_0BAD_F00D, 1'b1);

        // Random sets; set 2 fills the store exactly, sets 5 and 9 overflow it.
        set_no = 0;
        items  = 0;
        while (items < RANDOM_ITEMS || set_no < MIN_SETS)
        begin
            if (set_no == 2)
                set_size = MAX_CANDIDATES;
            else if (set_no == 5)
                set_size = MAX_CANDIDATES + 1;
            else if (set_no == 9)
                set_size = MAX_CANDIDATES + 3;
            else if ($urandom_range(9) == 0)
                set_size = $urandom_range(MAX_CANDIDATES + 4, MAX_CANDIDATES - 4);
            else
                set_size = $urandom_range(10, 1);
            calm = (set_no >= 6 && set_no < 10);
            if ($urandom_range(2) == 0)
                write_order(logic'($urandom_range(1)));
            flavor = $urandom_range(3);
            for (int k = 0; k < set_size; k++)
                send_candidate(pick_id(flavor), pick_seq(flavor), k == set_size - 1);
            items += set_size;
            set_no++;
        end

        calm = 1'b0;
        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("** recency_victim_ranker_core: PASSED **");
        else
            $display("** recency_victim_ranker_core: FAILED **");
        $finish;
    end

endmodule
